>>> src/kwq_pkg.sv
// Shared types, codes and default sizes for the keyed wait queue.
`default_nettype none

package kwq_pkg;

  localparam int DefaultDepth        = 16;
  localparam int DefaultKeyWidth     = 16;
  localparam int DefaultPayloadWidth = 16;
  localparam int CountWidth          = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_REMOVE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_NOMATCH  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic load;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

>>> src/kwq_ctrl.sv
// Controller state machine that sequences accept, rotation scan and response.
`default_nettype none

module kwq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  input  wire logic              op_i,
  input  wire kwq_pkg::ctl_sts_t sts_i,
  output kwq_pkg::ctl_cmd_t      cmd_o,
  output logic                   s_axis_tready
);
  import kwq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          if (op_i == OP_REMOVE && !sts_i.empty) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/kwq_datapath.sv
// Entry cells, occupancy count, head comparator and result registers.
`default_nettype none

module kwq_datapath #(
  parameter int DEPTH         = kwq_pkg::DefaultDepth,
  parameter int KEY_WIDTH     = kwq_pkg::DefaultKeyWidth,
  parameter int PAYLOAD_WIDTH = kwq_pkg::DefaultPayloadWidth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire kwq_pkg::ctl_cmd_t        cmd_i,
  input  wire logic                     op_i,
  input  wire logic [KEY_WIDTH-1:0]     key_i,
  input  wire logic [PAYLOAD_WIDTH-1:0] payload_i,
  input  wire logic                     m_ready_i,
  output kwq_pkg::ctl_sts_t             sts_o,
  output logic                          m_valid_o,
  output kwq_pkg::status_e              m_status_o,
  output logic [PAYLOAD_WIDTH-1:0]      m_payload_o,
  output logic [kwq_pkg::CountWidth-1:0] m_count_o
);
  import kwq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_WIDTH-1:0]     key_q [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_q [DEPTH];

  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            steps_q;
  logic [CW-1:0]            last_idx;
  logic [KEY_WIDTH-1:0]     req_key_q;
  status_e                  res_status_q;
  logic [PAYLOAD_WIDTH-1:0] res_pay_q;
  logic                     m_valid_q;
  status_e                  m_status_q;
  logic [PAYLOAD_WIDTH-1:0] m_pay_q;
  logic [CountWidth-1:0]    m_count_q;

  logic                     full;
  logic                     enq_we;
  logic                     drop;
  logic                     keep;
  logic [CW+CountWidth-1:0] count_ext;

  assign full      = (count_q == CW'(DEPTH));
  assign enq_we    = cmd_i.accept && (op_i == OP_ENQUEUE) && !full;
  assign drop      = cmd_i.step && (res_status_q != ST_REMOVED) && (key_q[0] == req_key_q);
  assign keep      = cmd_i.step && !drop;
  assign last_idx  = count_q - CW'(1);
  assign count_ext = {{CountWidth{1'b0}}, count_q};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] Idx = CW'(i);
    if (i < DEPTH - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (enq_we && (Idx == count_q)) begin
          key_q[i] <= key_i;
          pay_q[i] <= payload_i;
        end else if (keep && (Idx == last_idx)) begin
          key_q[i] <= key_q[0];
          pay_q[i] <= pay_q[0];
        end else if (cmd_i.step) begin
          key_q[i] <= key_q[i+1];
          pay_q[i] <= pay_q[i+1];
        end
      end
    end else begin : g_end
      always_ff @(posedge clk_i) begin
        if (enq_we && (Idx == count_q)) begin
          key_q[i] <= key_i;
          pay_q[i] <= payload_i;
        end else if (keep && (Idx == last_idx)) begin
          key_q[i] <= key_q[0];
          pay_q[i] <= pay_q[0];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (enq_we) begin
      count_d = count_q + CW'(1);
    end else if (drop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      steps_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.accept) begin
        steps_q <= count_q;
      end else if (cmd_i.step) begin
        steps_q <= steps_q - CW'(1);
      end
      if (cmd_i.load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_key_q <= key_i;
      res_pay_q <= '0;
      if (op_i == OP_REMOVE) begin
        res_status_q <= ST_NOMATCH;
      end else if (full) begin
        res_status_q <= ST_FULL;
      end else begin
        res_status_q <= ST_ENQUEUED;
      end
    end else if (drop) begin
      res_status_q <= ST_REMOVED;
      res_pay_q    <= pay_q[0];
    end
    if (cmd_i.load) begin
      m_status_q <= res_status_q;
      m_pay_q    <= res_pay_q;
      m_count_q  <= count_ext[CountWidth-1:0];
    end
  end

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.scan_last = (steps_q == CW'(1));
  assign sts_o.out_free  = !m_valid_q || m_ready_i;

  assign m_valid_o   = m_valid_q;
  assign m_status_o  = m_status_q;
  assign m_payload_o = m_pay_q;
  assign m_count_o   = m_count_q;

endmodule

`default_nettype wire

>>> src/keyed_wait_queue.sv
// Top level of the keyed wait queue: stream ports, controller and datapath.
//
//   Channel   Direction  tdata (low bit up)                         tuser
//   s_axis    in         key, payload                               operation
//   m_axis    out        status, removed_payload, entry_count (5)   none
//
// An enqueue or a remove on an empty queue goes from the accept straight to the response.
// A remove on a queue that holds n entries scans them all between accept and response, since
// every entry rotates once through the single head comparator.
// Reset clears the entry count, the scan counter and the handshake state only; the entry
// cells need no clearing pass. A new beat is accepted while a result waits on m_axis, and
// the following result holds in the response state until the output register is free.
`default_nettype none

module keyed_wait_queue #(
  parameter int DEPTH         = kwq_pkg::DefaultDepth,
  parameter int KEY_WIDTH     = kwq_pkg::DefaultKeyWidth,
  parameter int PAYLOAD_WIDTH = kwq_pkg::DefaultPayloadWidth,
  localparam int InW          = KEY_WIDTH + PAYLOAD_WIDTH,
  localparam int InTW         = ((InW + 7) / 8) * 8,
  localparam int OutW         = 2 + PAYLOAD_WIDTH + kwq_pkg::CountWidth,
  localparam int OutTW        = ((OutW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [InTW-1:0] s_axis_tdata,   // key, payload
  input  wire logic            s_axis_tuser,   // operation
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [OutTW-1:0]     m_axis_tdata    // status, removed_payload, entry_count
);
  import kwq_pkg::*;

  ctl_cmd_t                 cmd;
  ctl_sts_t                 sts;
  status_e                  m_status;
  logic [PAYLOAD_WIDTH-1:0] m_payload;
  logic [CountWidth-1:0]    m_count;

  kwq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .op_i          (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .s_axis_tready (s_axis_tready)
  );

  kwq_datapath #(
    .DEPTH         (DEPTH),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (s_axis_tuser),
    .key_i       (s_axis_tdata[KEY_WIDTH-1:0]),
    .payload_i   (s_axis_tdata[InW-1:KEY_WIDTH]),
    .m_ready_i   (m_axis_tready),
    .sts_o       (sts),
    .m_valid_o   (m_axis_tvalid),
    .m_status_o  (m_status),
    .m_payload_o (m_payload),
    .m_count_o   (m_count)
  );

  assign m_axis_tdata = OutTW'({m_count, m_payload, m_status});

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("A second beat was accepted while an item was still in work.");

  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[1:0] != ST_REMOVED)) |->
      (m_axis_tdata[PAYLOAD_WIDTH+1:2] == '0))
    else $error("A result without a removal carries a nonzero payload.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(m_axis_tdata[OutW-1:PAYLOAD_WIDTH+2]) <= DEPTH))
    else $error("The reported entry count exceeds the queue depth.");

endmodule

`default_nettype wire
